### rtl/mfm_pkg.sv
package mfm_pkg;

    localparam int unsigned NUM_FAULTS = 7;
    localparam int unsigned CFG_IDX_W  = 3;

    // Fault bit positions
    localparam int unsigned FB_HEARTBEAT = 0;
    localparam int unsigned FB_FEEDBACK  = 1;
    localparam int unsigned FB_NONFINITE = 2;
    localparam int unsigned FB_RANGE     = 3;
    localparam int unsigned FB_STALL     = 4;
    localparam int unsigned FB_QUEUE     = 5;
    localparam int unsigned FB_PARSE     = 6;

    // Operation codes; code three is unused and ignored
    localparam logic [1:0] OP_CHECK     = 2'd0;
    localparam logic [1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TARGET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_EPS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TMO    = 3'd6;

    localparam logic [30:0] Q31_MAX = 31'h7FFF_FFFF;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_HB_TIMEOUT   = 32'd100;
    localparam logic [31:0] RST_FB_TIMEOUT   = 32'd100;
    localparam logic [30:0] RST_MAX_SPEED    = 31'h7FFF_FFFF;
    localparam logic [30:0] RST_MAX_OUTPUT   = 31'h7FFF_FFFF;
    localparam logic [30:0] RST_STALL_TARGET = 31'd65536;
    localparam logic [30:0] RST_STALL_EPS    = 31'd6554;
    localparam logic [31:0] RST_STALL_TMO    = 32'd1000;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        now_tick;
        logic [31:0]        feedback_tick;
        logic signed [31:0] meas_speed;
        logic signed [31:0] drive_output;
        logic signed [31:0] cmd_speed;
        logic               values_nonfinite;
        logic               running;
        logic [31:0]        queue_full_total;
        logic [31:0]        parse_error_total;
    } req_item_t;

    typedef struct packed {
        logic [NUM_FAULTS-1:0] found_faults;
        logic [NUM_FAULTS-1:0] sticky_faults;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] control_heartbeat_timeout;
        logic [31:0] feedback_timeout;
        logic [30:0] max_abs_speed;
        logic [30:0] max_abs_output;
        logic [30:0] stall_target_min;
        logic [30:0] stall_speed_eps;
        logic [31:0] stall_timeout;
    } cfg_t;

    // Tick-width-independent part of the monitor state
    typedef struct packed {
        logic [NUM_FAULTS-1:0] fault_reg;
        logic                  stall_timing;
        logic [31:0]           seen_queue_full;
        logic [31:0]           seen_parse_errors;
    } mon_state_t;

    // Saturating magnitude of a signed Q16.16 value
    function automatic logic [30:0] abs_sat(input logic [31:0] v);
        logic [31:0] neg;
        neg = (~v) + 32'd1;
        if (!v[31]) begin
            abs_sat = v[30:0];
        end
        else if (v[30:0] == 31'd0) begin
            abs_sat = Q31_MAX;
        end
        else begin
            abs_sat = neg[30:0];
        end
    endfunction

endpackage

### rtl/mfm_cfg_regs.sv
module mfm_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [mfm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [31:0]                     wr_data,
    output mfm_pkg::cfg_t                   cfg
);
    import mfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_HB_TIMEOUT:   cfg_next.control_heartbeat_timeout = wr_data;
                REG_FB_TIMEOUT:   cfg_next.feedback_timeout          = wr_data;
                REG_MAX_SPEED:    cfg_next.max_abs_speed             = wr_data[30:0];
                REG_MAX_OUTPUT:   cfg_next.max_abs_output            = wr_data[30:0];
                REG_STALL_TARGET: cfg_next.stall_target_min          = wr_data[30:0];
                REG_STALL_EPS:    cfg_next.stall_speed_eps           = wr_data[30:0];
                REG_STALL_TMO:    cfg_next.stall_timeout             = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_heartbeat_timeout <= RST_HB_TIMEOUT;
            cfg_reg.feedback_timeout          <= RST_FB_TIMEOUT;
            cfg_reg.max_abs_speed             <= RST_MAX_SPEED;
            cfg_reg.max_abs_output            <= RST_MAX_OUTPUT;
            cfg_reg.stall_target_min          <= RST_STALL_TARGET;
            cfg_reg.stall_speed_eps           <= RST_STALL_EPS;
            cfg_reg.stall_timeout             <= RST_STALL_TMO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mfm_check.sv
module mfm_check #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  mfm_pkg::req_item_t      item,
    input  mfm_pkg::cfg_t           cfg,
    input  mfm_pkg::mon_state_t     state,
    input  logic [TICK_WIDTH-1:0]   last_hb_tick,
    input  logic [TICK_WIDTH-1:0]   stall_start_tick,
    output mfm_pkg::mon_state_t     state_next,
    output logic [TICK_WIDTH-1:0]   last_hb_tick_next,
    output logic [TICK_WIDTH-1:0]   stall_start_tick_next,
    output mfm_pkg::rsp_item_t      result
);
    import mfm_pkg::*;

    // Common width for comparing tick differences against 32-bit timeouts
    localparam int unsigned CW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

    logic [CW-1:0]          now_ext;
    logic [CW-1:0]          fb_ext;
    logic [TICK_WIDTH-1:0]  now_w;
    logic [TICK_WIDTH-1:0]  fb_w;
    logic [TICK_WIDTH-1:0]  hb_diff;
    logic [TICK_WIDTH-1:0]  fb_diff;
    logic [TICK_WIDTH-1:0]  st_diff;
    logic [30:0]            a_speed;
    logic [30:0]            a_out;
    logic [30:0]            a_target;
    logic                   stall_cond;
    logic [NUM_FAULTS-1:0]  found;

    assign now_ext = CW'(item.now_tick);
    assign fb_ext  = CW'(item.feedback_tick);
    assign now_w   = now_ext[TICK_WIDTH-1:0];
    assign fb_w    = fb_ext[TICK_WIDTH-1:0];

    assign hb_diff = now_w - last_hb_tick;
    assign fb_diff = now_w - fb_w;
    assign st_diff = now_w - stall_start_tick;

    assign a_speed  = abs_sat(item.meas_speed);
    assign a_out    = abs_sat(item.drive_output);
    assign a_target = abs_sat(item.cmd_speed);

    assign stall_cond = item.running
                      && (a_target > cfg.stall_target_min)
                      && (a_speed < cfg.stall_speed_eps);

    always_comb
    begin
        found                 = '0;
        state_next            = state;
        last_hb_tick_next     = last_hb_tick;
        stall_start_tick_next = stall_start_tick;
        case (item.op)
            OP_CHECK:
            begin
                found[FB_HEARTBEAT] = CW'(hb_diff) > CW'(cfg.control_heartbeat_timeout);
                found[FB_FEEDBACK]  = CW'(fb_diff) > CW'(cfg.feedback_timeout);
                found[FB_NONFINITE] = item.values_nonfinite;
                found[FB_RANGE]     = (a_speed > cfg.max_abs_speed)
                                    || (a_out > cfg.max_abs_output);
                if (stall_cond)
                begin
                    if (!state.stall_timing)
                    begin
                        state_next.stall_timing = 1'b1;
                        stall_start_tick_next   = now_w;
                    end
                    else
                    begin
                        found[FB_STALL] = CW'(st_diff) > CW'(cfg.stall_timeout);
                    end
                end
                else
                begin
                    state_next.stall_timing = 1'b0;
                end
                found[FB_QUEUE] = item.queue_full_total != state.seen_queue_full;
                found[FB_PARSE] = item.parse_error_total != state.seen_parse_errors;
                state_next.seen_queue_full   = item.queue_full_total;
                state_next.seen_parse_errors = item.parse_error_total;
                state_next.fault_reg         = state.fault_reg | found;
            end
            OP_HEARTBEAT:
            begin
                last_hb_tick_next = now_w;
            end
            OP_CLEAR:
            begin
                state_next            = '0;
                stall_start_tick_next = '0;
                last_hb_tick_next     = now_w;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign result.found_faults  = found;
    assign result.sticky_faults = state_next.fault_reg;

endmodule

### rtl/motor_fault_monitor_core.sv
// Motor fault monitor. Each request item is a check, a control heartbeat or a
// fault clear, and every item gives exactly one response item carrying the
// faults found by that item and the sticky fault register after it (bit 0
// heartbeat, 1 feedback, 2 non-finite, 3 range, 4 stall, 5 queue, 6 parse).
// Heartbeats and clears report no found faults; a clear also zeroes the sticky
// register, the seen error counters and stall timing, and restarts the
// heartbeat window at its now_tick. Tick differences are modulo 2^TICK_WIDTH,
// so the tick counter may wrap freely. Throughput is one item per clock while
// the response channel takes items. An accepted request item sits in the input
// register, then the combinational check logic fills the response register,
// where the monitor state is updated at the same edge; while the response
// register is full and not taken, the item waits in the input register.
// Configuration writes (cfg_ready is always high) are to be made while no
// item is in flight.
module motor_fault_monitor_core #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Request channel
    input  logic                            req_valid,
    output logic                            req_ready,
    input  mfm_pkg::req_item_t              req,

    // Response channel
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output mfm_pkg::rsp_item_t              rsp,

    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import mfm_pkg::*;

    cfg_t cfg;

    // Input stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    req_item_t              s1_item_reg;

    // Response stage
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    rsp_item_t              rsp_reg;

    // Monitor state
    mon_state_t             state_reg;
    mon_state_t             state_next;
    logic [TICK_WIDTH-1:0]  last_hb_tick_reg;
    logic [TICK_WIDTH-1:0]  last_hb_tick_next;
    logic [TICK_WIDTH-1:0]  stall_start_reg;
    logic [TICK_WIDTH-1:0]  stall_start_next;

    rsp_item_t              result;
    logic                   advance;
    logic                   req_accept;

    assign cfg_ready = 1'b1;

    mfm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mfm_check #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_check (
        .item                  (s1_item_reg),
        .cfg                   (cfg),
        .state                 (state_reg),
        .last_hb_tick          (last_hb_tick_reg),
        .stall_start_tick      (stall_start_reg),
        .state_next            (state_next),
        .last_hb_tick_next     (last_hb_tick_next),
        .stall_start_tick_next (stall_start_next),
        .result                (result)
    );

    // Item in the input stage moves on when the response register is free
    // or is being emptied this cycle.
    assign advance    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || advance;
    assign req_accept = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            state_reg        <= '0;
            last_hb_tick_reg <= '0;
            stall_start_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            // state commits only as the item leaves for the response register
            if (advance)
            begin
                state_reg        <= state_next;
                last_hb_tick_reg <= last_hb_tick_next;
                stall_start_reg  <= stall_start_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---- assertions ----

    // Found bits are always included in the sticky register.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.found_faults & ~rsp.sticky_faults) == '0))
        else $error("found fault missing from sticky register");

    // A clear item leaves a response with no faults at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.op == OP_CLEAR))
        |=> (rsp.found_faults == '0) && (rsp.sticky_faults == '0))
        else $error("clear item returned faults");

    // Sticky bits only drop through a clear item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && (s1_item_reg.op == OP_CLEAR))
        |=> (($past(state_reg.fault_reg) & ~state_reg.fault_reg) == '0))
        else $error("sticky fault bit lost without clear");

    // A stall fault needs stall timing already running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.found_faults[FB_STALL]) |-> state_reg.stall_timing)
        else $error("stall fault without stall timing");

endmodule

### tb/sv/tb_motor_fault_monitor_core.sv
`timescale 1ns / 1ps

module tb_motor_fault_monitor_core;

    import mfm_pkg::*;

    // Opcode three has no name in the package; the block ignores it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles with no accepted item on any channel before the run is abandoned.
    // The longest correct gaps come from random idling at 61 %.
    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_ready;
    req_item_t req = '0;

    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_item_t rsp;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Idle levels in percent, changed between phases
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    int mismatches = 0;
    int quiet_cycles = 0;

    // Items waiting to be offered, and results owed by the block, oldest first
    req_item_t items_to_send[$];
    rsp_item_t fault_reports_due[$];

    // Shadow of the configuration registers and of the monitor state
    cfg_t cfg_shadow;
    logic [NUM_FAULTS-1:0] sticky_now = '0;
    logic [31:0] hb_tick = '0;
    logic stall_armed = 1'b0;
    logic [31:0] stall_since = '0;
    logic [31:0] qf_seen = '0;
    logic [31:0] pe_seen = '0;

    // Stimulus generator state: a running tick, the error counters and the
    // number of items left in the current no-response episode
    logic [31:0] gen_tick = 32'hFFFF_F000;
    logic [31:0] gen_qf = '0;
    logic [31:0] gen_pe = '0;
    int stall_left = 0;

    motor_fault_monitor_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Magnitude of a signed Q16.16 pattern; the most negative value has no
    // positive counterpart and pins to the largest magnitude
    function automatic logic [30:0] q16_magnitude(logic [31:0] v);
        logic [31:0] flipped;
        if (v == 32'h8000_0000)
            return 31'h7FFF_FFFF;
        flipped = 32'd0 - v;
        return v[31] ? flipped[30:0] : v[30:0];
    endfunction

    // Works out the result of one item and moves the shadow state on
    function automatic rsp_item_t assess_item(req_item_t it);
        rsp_item_t res;
        logic [NUM_FAULTS-1:0] hit;
        logic [30:0] spd_mag;
        logic [30:0] out_mag;
        logic [30:0] tgt_mag;
        logic [31:0] since_hb;
        logic [31:0] since_fb;
        logic [31:0] since_stall;
        hit = '0;
        spd_mag = q16_magnitude(it.meas_speed);
        out_mag = q16_magnitude(it.drive_output);
        tgt_mag = q16_magnitude(it.cmd_speed);
        since_hb = it.now_tick - hb_tick;
        since_fb = it.now_tick - it.feedback_tick;
        since_stall = it.now_tick - stall_since;
        case (it.op)
            OP_HEARTBEAT: hb_tick = it.now_tick;
            OP_CLEAR:
            begin
                sticky_now = '0;
                qf_seen = '0;
                pe_seen = '0;
                stall_armed = 1'b0;
                stall_since = '0;
                hb_tick = it.now_tick;
            end
            OP_CHECK:
            begin
                if (since_hb > cfg_shadow.control_heartbeat_timeout)
                    hit[FB_HEARTBEAT] = 1'b1;
                if (since_fb > cfg_shadow.feedback_timeout)
                    hit[FB_FEEDBACK] = 1'b1;
                if (it.values_nonfinite)
                    hit[FB_NONFINITE] = 1'b1;
                if (spd_mag > cfg_shadow.max_abs_speed || out_mag > cfg_shadow.max_abs_output)
                    hit[FB_RANGE] = 1'b1;
                // No-response timing: first qualifying check arms it, later ones
                // compare against the arming tick
                if (it.running && tgt_mag > cfg_shadow.stall_target_min &&
                    spd_mag < cfg_shadow.stall_speed_eps)
                begin
                    if (!stall_armed)
                    begin
                        stall_armed = 1'b1;
                        stall_since = it.now_tick;
                    end
                    else if (since_stall > cfg_shadow.stall_timeout)
                    begin
                        hit[FB_STALL] = 1'b1;
                    end
                end
                else
                begin
                    stall_armed = 1'b0;
                end
                if (it.queue_full_total != qf_seen)
                begin
                    qf_seen = it.queue_full_total;
                    hit[FB_QUEUE] = 1'b1;
                end
                if (it.parse_error_total != pe_seen)
                begin
                    pe_seen = it.parse_error_total;
                    hit[FB_PARSE] = 1'b1;
                end
                sticky_now = sticky_now | hit;
            end
            default: ;
        endcase
        res.found_faults = hit;
        res.sticky_faults = sticky_now;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [NUM_FAULTS-1:0] got,
                                   logic [NUM_FAULTS-1:0] want);
        $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
        mismatches++;
    endtask

    // Request driver: offers queued items, predicts each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                fault_reports_due.push_back(assess_item(req));
            // Payload only moves once the current item has gone
            if (!req_valid || req_ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    req <= items_to_send.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: random back-pressure, field-by-field comparison
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_item_t due;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (rsp_valid && rsp_ready)
            begin
                if (fault_reports_due.size() == 0)
                begin
                    report_mismatch("result with none owed, found", rsp.found_faults, '0);
                end
                else
                begin
                    due = fault_reports_due.pop_front();
                    if (rsp.found_faults !== due.found_faults)
                        report_mismatch("found_faults", rsp.found_faults, due.found_faults);
                    if (rsp.sticky_faults !== due.sticky_faults)
                        report_mismatch("sticky_faults", rsp.sticky_faults, due.sticky_faults);
                end
            end
        end
    end

    // Watchdog on all three channels
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register write; the shadow follows at the accepting edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_HB_TIMEOUT:   cfg_shadow.control_heartbeat_timeout = data;
            REG_FB_TIMEOUT:   cfg_shadow.feedback_timeout = data;
            REG_MAX_SPEED:    cfg_shadow.max_abs_speed = data[30:0];
            REG_MAX_OUTPUT:   cfg_shadow.max_abs_output = data[30:0];
            REG_STALL_TARGET: cfg_shadow.stall_target_min = data[30:0];
            REG_STALL_EPS:    cfg_shadow.stall_speed_eps = data[30:0];
            REG_STALL_TMO:    cfg_shadow.stall_timeout = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(logic [1:0] op, logic [31:0] now, logic [31:0] fb,
                              logic [31:0] spd, logic [31:0] drv, logic [31:0] tgt,
                              logic nf, logic run, logic [31:0] qf, logic [31:0] pe);
        req_item_t it;
        it.op = op;
        it.now_tick = now;
        it.feedback_tick = fb;
        it.meas_speed = spd;
        it.drive_output = drv;
        it.cmd_speed = tgt;
        it.values_nonfinite = nf;
        it.running = run;
        it.queue_full_total = qf;
        it.parse_error_total = pe;
        items_to_send.push_back(it);
    endtask

    // Q16.16 value biased towards a limit, the extremes and small speeds
    function automatic logic [31:0] pick_q16(logic [30:0] near);
        logic [31:0] mag;
        case ($urandom_range(5))
            0, 1: return $urandom();
            2: mag = {1'b0, near} + $urandom_range(0, 4) - 32'd2;
            3: mag = $urandom_range(0, 32'h0004_0000);
            4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: mag = $urandom_range(0, 2000);
        endcase
        return $urandom_range(1) ? 32'd0 - mag : mag;
    endfunction

    // Plausible traffic: a tick that mostly creeps forward (with the odd jump),
    // feedback a little behind it, counters that seldom move, and episodes of
    // a running motor that ignores a large target
    task automatic queue_random_items(int count);
        int pick;
        logic [1:0] op;
        logic [31:0] fb;
        logic [31:0] spd;
        logic [31:0] drv;
        logic [31:0] tgt;
        logic run;
        logic [31:0] mag;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(49) == 0)
                gen_tick = $urandom();
            else
                gen_tick += $urandom_range(0, 60);
            pick = $urandom_range(99);
            if (pick < 78)
                op = OP_CHECK;
            else if (pick < 92)
                op = OP_HEARTBEAT;
            else if (pick < 97)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            fb = ($urandom_range(9) == 0) ? $urandom() : gen_tick - $urandom_range(0, 250);
            if (stall_left == 0 && $urandom_range(29) == 0)
                stall_left = $urandom_range(5, 40);
            drv = pick_q16(cfg_shadow.max_abs_output);
            if (stall_left != 0 && $urandom_range(9) != 0)
            begin
                run = 1'b1;
                mag = {1'b0, cfg_shadow.stall_target_min} + $urandom_range(1, 32'h0001_0000);
                tgt = $urandom_range(1) ? 32'd0 - mag : mag;
                mag = (cfg_shadow.stall_speed_eps == 0) ? 32'd0 :
                      $urandom_range(0, cfg_shadow.stall_speed_eps - 1);
                spd = $urandom_range(1) ? 32'd0 - mag : mag;
            end
            else
            begin
                run = 1'($urandom_range(1));
                tgt = pick_q16(cfg_shadow.stall_target_min);
                spd = pick_q16(cfg_shadow.max_abs_speed);
            end
            if (stall_left != 0)
                stall_left--;
            case ($urandom_range(19))
                0: gen_qf += 1;
                1: gen_qf = $urandom();
                default: ;
            endcase
            case ($urandom_range(19))
                0: gen_pe += 1;
                1: gen_pe = $urandom();
                default: ;
            endcase
            queue_item(op, gen_tick, fb, spd, drv, tgt, ($urandom_range(9) == 0), run,
                       gen_qf, gen_pe);
        end
    endtask

    // Block is idle once everything is sent and answered; then the bench
    // idles on before anything else happens
    task automatic wait_drained();
        while (items_to_send.size() != 0 || req_valid || fault_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int gap, int stall, logic [31:0] hb, logic [31:0] fb,
                             logic [31:0] spd, logic [31:0] outp, logic [31:0] tgt,
                             logic [31:0] eps, logic [31:0] stmo, int count);
        write_reg(REG_HB_TIMEOUT, hb);
        write_reg(REG_FB_TIMEOUT, fb);
        write_reg(REG_MAX_SPEED, spd);
        write_reg(REG_MAX_OUTPUT, outp);
        write_reg(REG_STALL_TARGET, tgt);
        write_reg(REG_STALL_EPS, eps);
        write_reg(REG_STALL_TMO, stmo);
        send_gap_pct <= gap;
        recv_stall_pct <= stall;
        queue_random_items(count);
        wait_drained();
    endtask

    initial
    begin
        cfg_shadow = '{RST_HB_TIMEOUT, RST_FB_TIMEOUT, RST_MAX_SPEED, RST_MAX_OUTPUT,
                       RST_STALL_TARGET, RST_STALL_EPS, RST_STALL_TMO};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Speed limit one below full scale so that the pinned
        // magnitude of the most negative value trips it; the output limit is
        // written with bit 31 set, which must be dropped.
        write_reg(REG_MAX_SPEED, 32'h7FFF_FFFE);
        write_reg(REG_MAX_OUTPUT, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_HEARTBEAT, 50, 0, 0, 0, 0, 0, 0, 0, 0);
        // Timeouts: exactly at the limit, then one past it
        queue_item(OP_CHECK, 150, 50, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CHECK, 151, 50, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CHECK, 151, 151, 0, 0, 0, 1, 0, 0, 0);
        // Range: most negative pins to full scale, then values on the limits and one past
        queue_item(OP_CHECK, 151, 151, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CHECK, 151, 151, 32'h7FFF_FFFE, 32'h8000_0000, 0, 0, 0, 0, 0);
        queue_item(OP_CHECK, 151, 151, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        // Error counters: a change, a second change, then no change
        queue_item(OP_CHECK, 151, 151, 0, 0, 0, 0, 0, 5, 0);
        queue_item(OP_CHECK, 151, 151, 0, 0, 0, 0, 0, 5, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 151, 151, 0, 0, 0, 0, 0, 5, 32'hFFFF_FFFF);
        // No response: arm, hold at the timeout, one past it, then a target
        // exactly at the threshold stops timing
        queue_item(OP_HEARTBEAT, 1000, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CHECK, 1000, 1000, 0, 0, 65537, 0, 1, 5, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 2000, 2000, -32'sd6553, 0, -32'sd65537, 0, 1, 5, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 2001, 2001, 0, 0, 65537, 0, 1, 5, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 2002, 2002, 0, 0, 65536, 0, 1, 5, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 2003, 2003, 6554, 0, 32'h8000_0000, 0, 1, 5, 32'hFFFF_FFFF);
        // Tick wrap on both differences
        queue_item(OP_HEARTBEAT, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CHECK, 32'h50, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 5, 32'hFFFF_FFFF);
        // Unused opcode with everything set: must leave the state alone
        queue_item(OP_UNUSED, 32'h7FFF_0000, 0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 1, 1, 32'h1234_5678, 32'h9ABC_DEF0);
        queue_item(OP_CLEAR, 32'h60, 0, 0, 0, 0, 1, 1, 7, 7);
        queue_item(OP_CHECK, 32'h60, 32'h60, 0, 0, 0, 0, 0, 5, 32'hFFFF_FFFF);
        queue_item(OP_CHECK, 32'h61, 32'h61, 0, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // Random phases across the idle levels and register settings: a nominal
        // setting first, then everything zero, then everything full scale
        run_phase(0, 0, 100, 100, 32'h0040_0000, 32'h0040_0000, 65536, 6554, 300, 116);
        run_phase(61, 0, 0, 0, 0, 0, 0, 0, 0, 116);
        run_phase(0, 61, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 116);
        for (int p = 0; p < 5; p++)
        begin
            run_phase((p % 4 == 0 || p % 4 == 1) ? 21 + 40 * (p % 2) : 0,
                      (p % 4 == 0 || p % 4 == 2) ? 21 + 40 * (p % 4 / 2) : 0,
                      $urandom_range(20, 300), $urandom_range(20, 300),
                      {1'($urandom_range(1)), 31'($urandom_range(0, 32'h0100_0000))},
                      {1'($urandom_range(1)), 31'($urandom_range(0, 32'h0100_0000))},
                      {1'($urandom_range(1)), 31'($urandom_range(0, 32'h0002_0000))},
                      {1'($urandom_range(1)), 31'($urandom_range(1, 32'h0004_0000))},
                      $urandom_range(0, 600), 116);
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
